FILE: src/cgpg_pkg.sv
// ----------------------------------------------------------------------------
// cgpg_pkg
// Shared types, constants and ramp table arithmetic for the crosshatch
// convergence pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cgpg_pkg;

  localparam int LINE_BITS      = 10;
  localparam int LEVEL_BITS     = 10;
  localparam int GRID_ROWS_BITS = 6;
  localparam int PHASE_BITS     = 20;
  localparam int RAMP_LEN_BITS  = 16;
  localparam int RECIP_BITS     = 23;
  localparam int INDEX_SHIFT    = 22;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 23;

  localparam int PHASE_STEP     = 256;
  localparam int DIV_BITS       = PHASE_BITS + 1;
  localparam int DIV_STEPS      = DIV_BITS;
  localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS + 1);

  localparam int RAMP_TABLE_DEPTH_DEF = 64;
  localparam int ROW_PERIOD_DEF       = 40;
  localparam int CENTER_ROW_DEF       = 285;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  // register defaults
  localparam int GRID_ROWS_RESET     = 4;
  localparam int WIDE_PERIOD_RESET   = 9331;
  localparam int NARROW_PERIOD_RESET = 4666;
  localparam int RAMP_LENGTH_RESET   = 691;
  localparam int RAMP_RECIP_RESET    = 6070;

  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_ROWS     = 3'd0,
    REG_WIDE_PERIOD   = 3'd1,
    REG_NARROW_PERIOD = 3'd2,
    REG_WIDE_START    = 3'd3,
    REG_NARROW_START  = 3'd4,
    REG_RAMP_LENGTH   = 3'd5,
    REG_RAMP_RECIP    = 3'd6
  } cgpg_reg_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV_Q,
    ST_HOLD_Q,
    ST_DIV_N
  } cgpg_state_e;

  typedef struct packed {
    logic [LINE_BITS-1:0] line_number;
    logic                 active;
    logic                 first_active;
  } cgpg_in_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  written;
  } cgpg_out_t;

  typedef struct packed {
    logic                load;
    logic [DIV_BITS-1:0] dividend;
  } cgpg_div_req_t;

  // cos in q30 on [0, pi/2], taylor series to eleven terms
  function automatic longint cos_q30(input logic [63:0] angle);
    logic [63:0] a2;
    logic [63:0] term;
    longint      acc;
    a2   = (angle * angle) >> 30;
    term = ONE_Q30;
    acc  = longint'(ONE_Q30);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * a2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return acc;
  endfunction

  // raised cosine table entry, upper half mirrored about pi/2
  function automatic logic [LEVEL_BITS-1:0] ramp_entry(input logic [63:0] angle,
                                                       input logic        upper);
    longint      c;
    longint      r;
    logic [63:0] v;
    if (upper) begin
      c = -cos_q30(PI_Q30 - angle);
    end else begin
      c = cos_q30(angle);
    end
    r = longint'(ONE_Q30) - c;
    if (r < 0) begin
      r = 0;
    end
    v = (64'(r) * 64'(LEVEL_MAX) + ONE_Q30) >> 31;
    if (v > 64'(LEVEL_MAX)) begin
      v = 64'(LEVEL_MAX);
    end
    return v[LEVEL_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/cgpg_row_mod.sv
// ----------------------------------------------------------------------------
// cgpg_row_mod
// Row position within a fixed row period about the center row, compared
// against the programmed grid row count.
// ----------------------------------------------------------------------------
`default_nettype none

module cgpg_row_mod import cgpg_pkg::*; #(
  parameter int DIVISOR = ROW_PERIOD_DEF,
  parameter int CENTER  = CENTER_ROW_DEF
) (
  input  logic [LINE_BITS-1:0]      line_i,
  input  logic [GRID_ROWS_BITS-1:0] grid_rows_i,
  output logic                      hit_o
);

  localparam int Offset     = (DIVISOR * 2048 - CENTER) % DIVISOR;
  localparam int SumBits    = $clog2((1 << LINE_BITS) + DIVISOR);
  localparam int RecipShift = 16;
  localparam int Recip      = (1 << RecipShift) / DIVISOR;
  localparam int ProdBits   = SumBits + RecipShift + 1;

  logic [SumBits-1:0]   sum;
  logic [ProdBits-1:0]  prod;
  logic [SumBits-1:0]   quot;
  logic [2*SumBits-1:0] quot_mul;
  logic [SumBits-1:0]   rem_raw;
  logic [SumBits-1:0]   rem;

  assign sum  = SumBits'(line_i) + SumBits'(Offset);
  // reciprocal estimate is low by at most one
  assign prod = ProdBits'(sum) * ProdBits'(Recip);
  assign quot = prod[RecipShift +: SumBits];
  assign quot_mul = (2*SumBits)'(quot) * (2*SumBits)'(DIVISOR);
  assign rem_raw  = sum - quot_mul[SumBits-1:0];
  assign rem      = (rem_raw >= SumBits'(DIVISOR)) ? rem_raw - SumBits'(DIVISOR) : rem_raw;
  assign hit_o    = rem < SumBits'(grid_rows_i);

endmodule

`default_nettype wire

FILE: src/cgpg_rem_div.sv
// ----------------------------------------------------------------------------
// cgpg_rem_div
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cgpg_rem_div import cgpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cgpg_div_req_t         req_i,
  input  logic [PHASE_BITS-1:0] divisor_i,
  output logic [PHASE_BITS-1:0] rem_o,
  output logic                  done_o
);

  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [PHASE_BITS-1:0]   rem_q;
  logic [DIV_BITS-1:0]     dvd_q;
  logic [DIV_BITS-1:0]     trial;
  logic [DIV_BITS-1:0]     diff;
  logic                    fits;

  assign trial = {rem_q, dvd_q[DIV_BITS-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.load) begin
      cnt_q <= DIV_CNT_BITS'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[PHASE_BITS-1:0] : trial[PHASE_BITS-1:0];
      dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
    end
  end

  assign rem_o  = rem_q;
  assign done_o = (cnt_q == '0);

endmodule

`default_nettype wire

FILE: src/cgpg_ramp_shaper.sv
// ----------------------------------------------------------------------------
// cgpg_ramp_shaper
// Maps the phase within one vertical line period to a sample level: full
// level on grid rows, else raised cosine ramp up, ramp down, then field black.
// ----------------------------------------------------------------------------
`default_nettype none

module cgpg_ramp_shaper import cgpg_pkg::*; #(
  parameter  int RAMP_TABLE_DEPTH = RAMP_TABLE_DEPTH_DEF,
  localparam int ScaleBits        = RECIP_BITS + $clog2(RAMP_TABLE_DEPTH)
) (
  input  logic                     hrow_i,
  input  logic [PHASE_BITS-1:0]    phase_i,
  input  logic [RAMP_LEN_BITS-1:0] ramp_length_i,
  input  logic [ScaleBits-1:0]     ramp_scale_i,
  output logic [LEVEL_BITS-1:0]    level_o
);

  localparam int IdxBits  = $clog2(RAMP_TABLE_DEPTH);
  localparam int ProdBits = RAMP_LEN_BITS + ScaleBits;
  localparam int ShBits   = ProdBits - INDEX_SHIFT;

  logic [LEVEL_BITS-1:0]    ramp_rom [RAMP_TABLE_DEPTH];
  logic [RAMP_LEN_BITS:0]   len2;
  logic                     in_up;
  logic                     in_down;
  logic [PHASE_BITS-1:0]    ramp_pos;
  logic [ProdBits-1:0]      prod;
  logic [ShBits-1:0]        shifted;
  logic [IdxBits-1:0]       idx;
  logic [LEVEL_BITS-1:0]    ramp_val;

  for (genvar g = 0; g < RAMP_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] Angle = (PI_Q30 * 64'(g)) / RAMP_TABLE_DEPTH;
    assign ramp_rom[g] = ramp_entry(Angle, (2 * g > RAMP_TABLE_DEPTH));
  end

  assign len2     = {ramp_length_i, 1'b0};
  assign in_up    = phase_i < PHASE_BITS'(ramp_length_i);
  assign in_down  = phase_i < PHASE_BITS'(len2);
  assign ramp_pos = in_up ? phase_i : phase_i - PHASE_BITS'(ramp_length_i);

  // position inside a ramp is below ramp_length, so 16 bits carry it
  assign prod    = ProdBits'(ramp_pos[RAMP_LEN_BITS-1:0]) * ProdBits'(ramp_scale_i);
  assign shifted = prod[ProdBits-1:INDEX_SHIFT];
  assign idx     = (shifted > ShBits'(RAMP_TABLE_DEPTH - 1)) ? IdxBits'(RAMP_TABLE_DEPTH - 1)
                                                              : shifted[IdxBits-1:0];
  assign ramp_val = ramp_rom[idx];

  always_comb begin
    priority if (hrow_i) begin
      level_o = LEVEL_MAX;
    end else if (in_up) begin
      level_o = ramp_val;
    end else if (in_down) begin
      level_o = LEVEL_MAX - ramp_val;
    end else begin
      level_o = '0;
    end
  end

endmodule

`default_nettype wire

FILE: src/convergence_grid_pattern_generator.sv
// ----------------------------------------------------------------------------
// convergence_grid_pattern_generator
// Crosshatch convergence pattern, one sample level per input request.
// Registers: a taken request enters the input register; its result then
//   leaves through the result register.
// Throughput: one request per cycle while the output is free and the phase
//   and stepped phase lie below twice the line period; else the 21-step
//   remainder unit runs once or twice and holds that request meanwhile.
// Reset: asynchronous; registers take their defaults, phase clears to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module convergence_grid_pattern_generator import cgpg_pkg::*; #(
  parameter int RAMP_TABLE_DEPTH = RAMP_TABLE_DEPTH_DEF,
  parameter int ROW_PERIOD       = ROW_PERIOD_DEF,
  parameter int CENTER_ROW       = CENTER_ROW_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  cgpg_in_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output cgpg_out_t                out_data_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  localparam int HalfPeriod = ROW_PERIOD / 2;
  localparam int ScaleBits  = RECIP_BITS + $clog2(RAMP_TABLE_DEPTH);

  typedef struct packed {
    logic active;
    logic first;
    logic hrow;
    logic narrow;
  } item_t;

  // configuration
  logic [GRID_ROWS_BITS-1:0] grid_rows_q;
  logic [PHASE_BITS-1:0]     wide_period_q;
  logic [PHASE_BITS-1:0]     narrow_period_q;
  logic [PHASE_BITS-1:0]     wide_start_q;
  logic [PHASE_BITS-1:0]     narrow_start_q;
  logic [RAMP_LEN_BITS-1:0]  ramp_length_q;
  logic [ScaleBits-1:0]      ramp_scale_q;

  // pipeline
  logic                      item_valid_q;
  item_t                     item_q;
  logic                      out_valid_q;
  cgpg_out_t                 out_q;
  logic [PHASE_BITS-1:0]     grid_phase_q;
  logic [PHASE_BITS-1:0]     q_hold_q;
  cgpg_state_e               state_q;
  cgpg_state_e               state_d;

  logic                      hrow_hit;
  logic                      narrow_hit;
  logic                      accept;
  logic                      out_free;
  logic                      can_done;
  logic                      pop;
  logic                      hold_load;
  logic [PHASE_BITS-1:0]     hold_value;
  cgpg_div_req_t             div_req;
  logic [PHASE_BITS-1:0]     div_rem;
  logic                      div_done;

  logic [PHASE_BITS-1:0]     period;
  logic [PHASE_BITS-1:0]     start_phase;
  logic [PHASE_BITS-1:0]     x;
  logic [PHASE_BITS:0]       p_ext;
  logic [PHASE_BITS:0]       x_sub;
  logic                      p_zero;
  logic                      x_lt;
  logic                      q_fast_ok;
  logic [PHASE_BITS-1:0]     q_fast;
  logic [PHASE_BITS-1:0]     q_cur;
  logic [PHASE_BITS:0]       n;
  logic [PHASE_BITS:0]       n_sub;
  logic                      n_lt;
  logic                      n_fast_ok;
  logic [PHASE_BITS-1:0]     n_fast;
  logic                      fast_done;
  logic [PHASE_BITS-1:0]     next_phase;
  logic [LEVEL_BITS-1:0]     level;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q     <= GRID_ROWS_BITS'(GRID_ROWS_RESET);
      wide_period_q   <= PHASE_BITS'(WIDE_PERIOD_RESET);
      narrow_period_q <= PHASE_BITS'(NARROW_PERIOD_RESET);
      wide_start_q    <= '0;
      narrow_start_q  <= '0;
      ramp_length_q   <= RAMP_LEN_BITS'(RAMP_LENGTH_RESET);
      ramp_scale_q    <= ScaleBits'(RAMP_RECIP_RESET * RAMP_TABLE_DEPTH);
    end else if (cfg_we_i) begin
      unique case (cgpg_reg_e'(cfg_idx_i))
        REG_GRID_ROWS:     grid_rows_q     <= cfg_wdata_i[GRID_ROWS_BITS-1:0];
        REG_WIDE_PERIOD:   wide_period_q   <= cfg_wdata_i[PHASE_BITS-1:0];
        REG_NARROW_PERIOD: narrow_period_q <= cfg_wdata_i[PHASE_BITS-1:0];
        REG_WIDE_START:    wide_start_q    <= cfg_wdata_i[PHASE_BITS-1:0];
        REG_NARROW_START:  narrow_start_q  <= cfg_wdata_i[PHASE_BITS-1:0];
        REG_RAMP_LENGTH:   ramp_length_q   <= cfg_wdata_i[RAMP_LEN_BITS-1:0];
        // table scale kept premultiplied by the table depth
        REG_RAMP_RECIP:    ramp_scale_q    <= ScaleBits'(cfg_wdata_i[RECIP_BITS-1:0]) *
                                              ScaleBits'(RAMP_TABLE_DEPTH);
        default: ;
      endcase
    end
  end

  // ---------------- row tests at the input ----------------
  cgpg_row_mod #(
    .DIVISOR (ROW_PERIOD),
    .CENTER  (CENTER_ROW)
  ) u_hrow (
    .line_i      (in_data_i.line_number),
    .grid_rows_i (grid_rows_q),
    .hit_o       (hrow_hit)
  );

  cgpg_row_mod #(
    .DIVISOR (HalfPeriod),
    .CENTER  (CENTER_ROW)
  ) u_nrow (
    .line_i      (in_data_i.line_number),
    .grid_rows_i (grid_rows_q),
    .hit_o       (narrow_hit)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop        = can_done && out_free;
  assign in_stall_o = item_valid_q && !pop;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (accept) begin
      item_valid_q <= 1'b1;
    end else if (pop) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{active: in_data_i.active, first: in_data_i.first_active,
                  hrow: hrow_hit, narrow: narrow_hit};
    end
  end

  // ---------------- phase reduction ----------------
  assign period      = item_q.narrow ? narrow_period_q : wide_period_q;
  assign start_phase = item_q.narrow ? narrow_start_q : wide_start_q;
  assign x           = item_q.first ? start_phase : grid_phase_q;
  assign p_ext       = {1'b0, period};
  assign p_zero      = (period == '0);
  assign x_lt        = x < period;
  assign x_sub       = {1'b0, x} - p_ext;
  assign q_fast_ok   = p_zero || x_lt || (x_sub < p_ext);
  assign q_fast      = (p_zero || x_lt) ? x : x_sub[PHASE_BITS-1:0];
  assign q_cur       = (state_q == ST_RUN) ? q_fast : q_hold_q;

  assign n         = {1'b0, q_cur} + (PHASE_BITS+1)'(PHASE_STEP);
  assign n_lt      = n < p_ext;
  assign n_sub     = n - p_ext;
  // zero period wraps at the phase width
  assign n_fast_ok = p_zero || n_lt || (n_sub < p_ext);
  assign n_fast    = (p_zero || n_lt) ? n[PHASE_BITS-1:0] : n_sub[PHASE_BITS-1:0];
  assign fast_done = q_fast_ok && n_fast_ok;

  assign next_phase = (state_q == ST_DIV_N) ? div_rem : n_fast;

  cgpg_rem_div u_rem_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .divisor_i (period),
    .rem_o     (div_rem),
    .done_o    (div_done)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (item_valid_q && item_q.active && !fast_done) begin
          state_d = q_fast_ok ? ST_DIV_N : ST_DIV_Q;
        end
      end
      ST_DIV_Q: begin
        if (div_done) begin
          state_d = ST_HOLD_Q;
        end
      end
      ST_HOLD_Q: begin
        priority if (!n_fast_ok) begin
          state_d = ST_DIV_N;
        end else if (out_free) begin
          state_d = ST_RUN;
        end
      end
      ST_DIV_N: begin
        if (div_done && out_free) begin
          state_d = ST_RUN;
        end
      end
    endcase
  end

  always_comb begin
    can_done         = 1'b0;
    hold_load        = 1'b0;
    hold_value       = q_fast;
    div_req.load     = 1'b0;
    div_req.dividend = n;
    unique case (state_q)
      ST_RUN: begin
        if (item_valid_q) begin
          priority if (!item_q.active || fast_done) begin
            can_done = 1'b1;
          end else if (!q_fast_ok) begin
            div_req.load     = 1'b1;
            div_req.dividend = {1'b0, x};
          end else begin
            hold_load    = 1'b1;
            div_req.load = 1'b1;
          end
        end
      end
      ST_DIV_Q: begin
        hold_load  = div_done;
        hold_value = div_rem;
      end
      ST_HOLD_Q: begin
        can_done     = n_fast_ok;
        div_req.load = !n_fast_ok;
      end
      ST_DIV_N: begin
        can_done = div_done;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      grid_phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (pop && item_q.active) begin
        grid_phase_q <= next_phase;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_load) begin
      q_hold_q <= hold_value;
    end
  end

  // ---------------- level and result register ----------------
  cgpg_ramp_shaper #(
    .RAMP_TABLE_DEPTH (RAMP_TABLE_DEPTH)
  ) u_ramp_shaper (
    .hrow_i        (item_q.hrow),
    .phase_i       (q_cur),
    .ramp_length_i (ramp_length_q),
    .ramp_scale_i  (ramp_scale_q),
    .level_o       (level)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q.level   <= item_q.active ? level : '0;
      out_q.written <= item_q.active;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: src/cgpg_checker.sv
// ----------------------------------------------------------------------------
// cgpg_checker
// Port-level checks for the convergence pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

module cgpg_checker import cgpg_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire cgpg_out_t out_data_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // skipped samples carry black
  a_skip_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.written |-> out_data_o.level == '0)
    else $error("unwritten sample with nonzero level");

  // reset empties both ends of the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty in reset");

endmodule

bind convergence_grid_pattern_generator cgpg_checker u_cgpg_checker (.*);

`default_nettype wire
